>>> rtl/core/crpdo_pkg.sv
// shared types, codes and constants of the rpdo match and timeout core
package crpdo_pkg;

	localparam int DEFAULT_SLOTS = 4;
	localparam int MAX_SLOTS     = 8;
	localparam int ID_W          = 11;
	localparam int TMO_W         = 16;
	localparam int TIME_W        = 32;
	localparam int DATA_W        = 64;
	localparam int CFG_ADDR_W    = 3;
	localparam int CFG_DATA_W    = 16;
	localparam int REG_SLOTS     = 4;
	localparam int MASK_W        = 4;
	localparam int SLOT_W        = 2;

	localparam logic [ID_W-1:0] ID_MASK = 11'h7FF;

	// item kinds, code 3 is unused and gives an all-zero result with no change
	typedef enum logic [1:0] {
		OP_FRAME = 2'd0,
		OP_TICK  = 2'd1,
		OP_RESET = 2'd2
	} op_t;

	// register file halves, selected by the top index bit
	localparam logic REG_BANK_RX_ID   = 1'b0;
	localparam logic REG_BANK_TIMEOUT = 1'b1;

	// reset identifier of a slot: 0x201 + 0x100 * slot, kept to eleven bits
	function automatic logic [ID_W-1:0] default_id(input int unsigned idx);
		logic [31:0] full;
		full = 32'h201 + (32'h100 * idx);
		return full[ID_W-1:0] & ID_MASK;
	endfunction

endpackage

>>> rtl/core/canopen_rpdo_match_and_timeout_core.sv
// rpdo receive slot matcher with per-slot event timers, top level
//
// Each item (a received frame, a millisecond tick or a timer reset) enters an
// input register, is resolved by one level of logic against the slot table and
// the per-slot timer state, and lands in a result register, so an item goes in
// every clock cycle when nothing stalls. The rate is one item per cycle; the
// only thing that slows it is stall on the result side, which holds the result
// register and, once the input register is also full, raises in_stall. Frames
// match all slots in parallel and the lowest matching slot wins; a match claims
// the frame, and only while operational it restamps the slot, clears its expired
// mark and hands the payload on. A tick, while operational, compares the wrapped
// 32-bit age of every enabled, not yet expired slot with its timeout and reports
// the slots that just expired. A reset item restamps all slots with now_ms
// whatever the operational input says. Identifiers and timeouts are written
// through the cfg port (indexes 0..3 identifiers, 4..7 timeouts); the user must
// write them only while the core is idle, which the core does not enforce.
// Slots above the fourth keep their reset identifier and no timeout.
module canopen_rpdo_match_and_timeout_core #(
	parameter int SLOTS = crpdo_pkg::DEFAULT_SLOTS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration write port
	input  logic                             cfg_we,
	input  logic [crpdo_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [crpdo_pkg::CFG_DATA_W-1:0] cfg_wdata,
	// item channel
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [1:0]                       op,
	input  logic [crpdo_pkg::ID_W-1:0]       frame_id,
	input  logic [crpdo_pkg::DATA_W-1:0]     frame_data,
	input  logic [crpdo_pkg::TIME_W-1:0]     now_ms,
	input  logic                             operational,
	// result channel
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             claimed,
	output logic                             delivered,
	output logic [crpdo_pkg::SLOT_W-1:0]     slot,
	output logic [crpdo_pkg::DATA_W-1:0]     data_out,
	output logic [crpdo_pkg::MASK_W-1:0]     timeout_mask
);

	import crpdo_pkg::*;

	// width of the slot vector once padded to cover the result mask
	localparam int PadW = (SLOTS > MASK_W) ? SLOTS : MASK_W;

	// slot table and timer state
	logic [ID_W-1:0]   rx_id_q        [SLOTS];
	logic [TMO_W-1:0]  tmo_q          [SLOTS];
	logic [TIME_W-1:0] last_receive_q [SLOTS];
	logic [SLOTS-1:0]  expired_q;

	// input register
	logic              valid_s1;
	logic [1:0]        op_s1;
	logic [ID_W-1:0]   frame_id_s1;
	logic [DATA_W-1:0] frame_data_s1;
	logic [TIME_W-1:0] now_s1;
	logic              oper_s1;

	// result register
	logic              out_valid_q;
	logic              claimed_q;
	logic              delivered_q;
	logic [SLOT_W-1:0] slot_q;
	logic [DATA_W-1:0] data_q;
	logic [MASK_W-1:0] mask_q;

	// handshake control
	logic out_take;
	logic advance;
	logic in_take;

	// combinational results for the item in the input register
	logic [SLOTS-1:0]  hit_vec;
	logic [SLOTS-1:0]  win_vec;
	logic              any_hit;
	logic [SLOT_W-1:0] win_slot;
	logic [SLOTS-1:0]  due_vec;
	logic [PadW-1:0]   due_pad;
	logic              frame_dlv;
	logic              res_claimed;
	logic              res_delivered;
	logic [SLOT_W-1:0] res_slot;
	logic [DATA_W-1:0] res_data;
	logic [MASK_W-1:0] res_mask;
	logic [SLOTS-1:0]  restamp_vec;
	logic [SLOTS-1:0]  expire_set;
	logic [SLOTS-1:0]  expire_clr;

	// result register drains on a transfer, input register moves when there is room
	assign out_take = out_valid_q && !out_stall;
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	// identifier compare on every slot, then lowest match wins
	always_comb begin
		logic found;
		found    = 1'b0;
		win_vec  = '0;
		win_slot = '0;
		for (int i = 0; i < SLOTS; i++) begin
			hit_vec[i] = (rx_id_q[i] == frame_id_s1);
			if (hit_vec[i] && !found) begin
				found      = 1'b1;
				win_vec[i] = 1'b1;
				win_slot   = SLOT_W'(i);
			end
		end
		any_hit = found;
	end

	// wrapped age against timeout, for enabled slots not yet expired
	always_comb begin
		logic [TIME_W-1:0] age;
		for (int i = 0; i < SLOTS; i++) begin
			age        = now_s1 - last_receive_q[i];
			due_vec[i] = (tmo_q[i] != '0) && !expired_q[i] &&
			             (age >= TIME_W'(tmo_q[i]));
		end
	end

	// only the first slots have a bit in the reported mask
	assign due_pad = PadW'(due_vec);

	// result and state update for the item kind
	always_comb begin
		frame_dlv     = any_hit && oper_s1;
		res_claimed   = 1'b0;
		res_delivered = 1'b0;
		res_slot      = '0;
		res_data      = '0;
		res_mask      = '0;
		restamp_vec   = '0;
		expire_set    = '0;
		expire_clr    = '0;
		case (op_s1)
			OP_FRAME: begin
				res_claimed   = any_hit;
				res_slot      = any_hit ? win_slot : '0;
				res_delivered = frame_dlv;
				res_data      = frame_dlv ? frame_data_s1 : '0;
				if (frame_dlv) begin
					restamp_vec = win_vec;
					expire_clr  = win_vec;
				end
			end
			OP_TICK: begin
				if (oper_s1) begin
					expire_set = due_vec;
					res_mask   = due_pad[MASK_W-1:0];
				end
			end
			OP_RESET: begin
				restamp_vec = '1;
				expire_clr  = '1;
			end
			default: begin
				// unused code: no change, all-zero result
				res_claimed = 1'b0;
			end
		endcase
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			op_s1         <= op;
			frame_id_s1   <= frame_id;
			frame_data_s1 <= frame_data;
			now_s1        <= now_ms;
			oper_s1       <= operational;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			claimed_q   <= res_claimed;
			delivered_q <= res_delivered;
			slot_q      <= res_slot;
			data_q      <= res_data;
			mask_q      <= res_mask;
		end
	end

	// slot table, only the first slots are reachable from the cfg port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				rx_id_q[i] <= default_id(i);
				tmo_q[i]   <= '0;
			end
		end else if (cfg_we) begin
			for (int i = 0; i < SLOTS; i++) begin
				if (i < REG_SLOTS && cfg_addr[SLOT_W-1:0] == SLOT_W'(i)) begin
					if (cfg_addr[CFG_ADDR_W-1] == REG_BANK_RX_ID) begin
						rx_id_q[i] <= cfg_wdata[ID_W-1:0] & ID_MASK;
					end else begin
						tmo_q[i] <= cfg_wdata[TMO_W-1:0];
					end
				end
			end
		end
	end

	// timer state, changed when an item leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				last_receive_q[i] <= '0;
			end
			expired_q <= '0;
		end else if (advance) begin
			for (int i = 0; i < SLOTS; i++) begin
				if (restamp_vec[i]) begin
					last_receive_q[i] <= now_s1;
				end
			end
			expired_q <= (expired_q | expire_set) & ~expire_clr;
		end
	end

	assign out_valid    = out_valid_q;
	assign claimed      = claimed_q;
	assign delivered    = delivered_q;
	assign slot         = slot_q;
	assign data_out     = data_q;
	assign timeout_mask = mask_q;

`ifndef SYNTH
	// a delivered frame is always a claimed one
	a_dlv_claimed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && delivered_q |-> claimed_q)
		else $error("delivered result without claim");

	// payload only travels with a delivery
	a_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !delivered_q |-> data_q == '0)
		else $error("payload on undelivered result");

	// a tick mask never comes with a frame result
	a_mask_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && mask_q != '0 |-> !claimed_q)
		else $error("timeout mask on a frame result");

	// a slot reported as timed out is marked expired afterwards
	a_mask_marks: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res_mask != '0 |=>
		(PadW'(expired_q) & PadW'($past(res_mask))) == PadW'($past(res_mask)))
		else $error("reported timeout not marked expired");
`endif

endmodule
